[hdl/multi_tap_feedback_delay_assert.svh]
// Assertion macros for the delay block checker
`ifndef MULTI_TAP_FEEDBACK_DELAY_ASSERT_SVH
`define MULTI_TAP_FEEDBACK_DELAY_ASSERT_SVH

`define MTFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define MTFD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mtfd_pkg.sv]
package mtfd_pkg;

	localparam int DEPTH_W   = 17;
	localparam int DEPTH     = 1 << DEPTH_W;
	localparam int CHANNELS  = 2;
	localparam int CH_W      = 1;
	localparam int SAMPLE_W  = 24;
	localparam int ADDR_W    = CH_W + DEPTH_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;

	localparam int NUM_W     = 23;
	localparam int DEN_W     = 30;
	localparam int QUO_W     = 23;
	localparam int CNT_W     = 5;

	localparam logic [16:0] MIN_MIX   = 17'd7;
	localparam logic [16:0] UNITY     = 17'd65536;
	localparam logic [15:0] FB_MAX    = 16'd60293;
	localparam logic [16:0] BASE_RST  = 17'd4800;

	localparam logic [16:0] K_WA      = 17'd36045;
	localparam logic [16:0] K_WB0     = 17'd22938;
	localparam logic [16:0] K_WB1     = 17'd13107;
	localparam logic [17:0] K_CB0     = 18'd32768;
	localparam logic [16:0] K_CB1     = 17'd29491;
	localparam logic [17:0] K_CC0     = 18'd81920;
	localparam logic [16:0] K_CC1     = 17'd45875;
	localparam logic [13:0] K_SOFT    = 14'd9830;

	typedef enum logic [1:0] {
		REG_BASE   = 2'd0,
		REG_FB     = 2'd1,
		REG_SPREAD = 2'd2,
		REG_MIX    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [16:0] base;
		logic [15:0] fb;
		logic [16:0] spread;
		logic [16:0] mix;
	} cfg_t;

	typedef struct packed {
		logic                       ch;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       bypass;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

[hdl/multi_tap_feedback_delay.sv]
// Multi-tap feedback delay, two audio channels.
// Input channel: in_valid/in_ready carry one Q3.20 sample with its channel
// number. Output channel: out_valid/out_ready carry one Q3.20 sample per
// input sample, in order.
// Settings: write wr_data to register wr_index when wr_en is high (base
// delay, feedback gain, tap spread, wet mix); write only while idle.
// A delay sample passes through the tap, memory read, multiply, feedback,
// soft limit divide and mix states; a bypassed sample (mix below 7) goes
// straight to the output register. The engine takes one sample at a time,
// paced by three reads on one memory read port and the 23-step dividers.
// A two-entry request queue sits in front of the engine, so samples are
// accepted while the engine works or the output waits.
// Reset clears registers to their defaults, empties the queue and zeroes
// the write positions; unwritten line entries read as zero.
// While out_ready is low the result is held and the engine stops with its
// next result; the queue then fills and in_ready drops.
module multi_tap_feedback_delay (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mtfd_pkg::CH_W-1:0]            channel,
	input  logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [16:0]                          wr_data
);
	import mtfd_pkg::*;

	cfg_t        cfg_q;
	queue_head_t head;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= BASE_RST;
			cfg_q.fb     <= '0;
			cfg_q.spread <= '0;
			cfg_q.mix    <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_BASE:   cfg_q.base   <= wr_data;
				REG_FB:     cfg_q.fb     <= wr_data[15:0];
				REG_SPREAD: cfg_q.spread <= wr_data;
				REG_MIX:    cfg_q.mix    <= wr_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	mtfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.channel   (channel),
		.sample_in (sample_in),
		.head      (head),
		.pop       (pop)
	);

	mtfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule

[hdl/mtfd_front.sv]
module mtfd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtfd_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mtfd_pkg::CH_W-1:0]           channel,
	input  logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_in,
	output mtfd_pkg::queue_head_t               head,
	input  logic                                pop
);
	import mtfd_pkg::*;

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               do_pop;
	item_t              new_item;

	assign in_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (cnt_q != '0);

	assign new_item.ch     = channel;
	assign new_item.sample = sample_in;
	assign new_item.bypass = (cfg.mix < MIN_MIX) || (32'(channel) >= CHANNELS);

	assign head.valid = (cnt_q != '0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/mtfd_div.sv]
module mtfd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mtfd_pkg::NUM_W-1:0]    num,
	input  logic [mtfd_pkg::DEN_W-1:0]    den,
	output logic                          done,
	output logic [mtfd_pkg::QUO_W-1:0]    quo
);
	import mtfd_pkg::*;

	localparam int N_W = NUM_W + 21;

	logic [N_W-1:0]   dividend;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] bits_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             take;

	assign dividend = {1'b0, num, 20'd0} + N_W'(den >> 1);
	assign trial    = {rem_q, bits_q[QUO_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign take     = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quo      = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DEN_W'(dividend[N_W-1:QUO_W]);
			bits_q <= dividend[QUO_W-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[QUO_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hdl/mtfd_back.sv]
module mtfd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mtfd_pkg::cfg_t                       cfg,
	input  mtfd_pkg::queue_head_t                head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_out
);
	import mtfd_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_COEF = 16'b0000_0000_0000_0010,
		S_TAPS = 16'b0000_0000_0000_0100,
		S_RDA  = 16'b0000_0000_0000_1000,
		S_RDB  = 16'b0000_0000_0001_0000,
		S_RDC  = 16'b0000_0000_0010_0000,
		S_RDW  = 16'b0000_0000_0100_0000,
		S_MUL  = 16'b0000_0000_1000_0000,
		S_WET  = 16'b0000_0001_0000_0000,
		S_FB   = 16'b0000_0010_0000_0000,
		S_LIN  = 16'b0000_0100_0000_0000,
		S_DEN  = 16'b0000_1000_0000_0000,
		S_GO   = 16'b0001_0000_0000_0000,
		S_DIV  = 16'b0010_0000_0000_0000,
		S_MIX  = 16'b0100_0000_0000_0000,
		S_DONE = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic [SAMPLE_W-1:0]        store_q [CHANNELS*DEPTH];
	logic [SAMPLE_W-1:0]        rd_q;
	logic [ADDR_W-1:0]          raddr;
	logic                       we;

	logic [DEPTH_W-1:0]         pos_q  [CHANNELS];
	logic                       wrap_q [CHANNELS];

	logic                       ch_q;
	logic                       byp_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [17:0]                cb_q;
	logic [17:0]                cc_q;
	logic [16:0]                wb_q;
	logic [DEPTH_W-1:0]         ia_q, ib_q, ic_q;
	logic                       va_q, vb_q, vc_q;
	logic signed [SAMPLE_W-1:0] a_q, b_q, c_q;
	logic signed [41:0]         pa_q, pb_q;
	logic signed [27:0]         wet_q;
	logic signed [44:0]         pf_q;
	logic signed [29:0]         lin_q;
	logic [NUM_W-1:0]           num_w_q, num_l_q;
	logic [DEN_W-1:0]           den_w_q, den_l_q;
	logic                       neg_w_q, neg_l_q;
	logic signed [SAMPLE_W-1:0] slw_q, sll_q;
	logic signed [42:0]         m1_q, m2_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic [16:0]                sp_c, mix_c, base_c;
	logic [15:0]                fb_c;
	logic [DEPTH_W-1:0]         pos_c;
	logic [DEPTH_W-1:0]         tb_c, tc_c, ia_c, ib_c, ic_c;
	logic signed [43:0]         wet_sum_c;
	logic signed [29:0]         lin_c;
	logic [29:0]                axw_c, axl_c;
	logic                       start;
	logic                       done_w, done_l;
	logic [QUO_W-1:0]           qw, ql;
	logic signed [43:0]         y_sum_c;
	logic signed [26:0]         y_c;
	logic signed [SAMPLE_W-1:0] y_sat_c;
	logic                       out_free;

	function automatic logic [DEPTH_W-1:0] clamp_tap(input logic [34:0] prod);
		logic [18:0] t;
		t = 19'((prod + 35'd32768) >> 16);
		if (t == '0)
			return DEPTH_W'(1);
		if (t > 19'(DEPTH - 1))
			return DEPTH_W'(DEPTH - 1);
		return t[DEPTH_W-1:0];
	endfunction

	function automatic logic [29:0] mag(input logic signed [29:0] v);
		return v[29] ? 30'(-v) : 30'(v);
	endfunction

	function automatic logic [DEN_W-1:0] soft_den(input logic [29:0] ax);
		logic [43:0] p;
		p = 44'(ax) * 44'(K_SOFT) + 44'd32768;
		return DEN_W'(1 << 20) + DEN_W'(p >> 16);
	endfunction

	function automatic logic [NUM_W-1:0] soft_num(input logic [29:0] ax);
		return (ax > 30'(4 << 20)) ? NUM_W'(4 << 20) : ax[NUM_W-1:0];
	endfunction

	assign sp_c   = (cfg.spread > UNITY) ? UNITY : cfg.spread;
	assign mix_c  = (cfg.mix > UNITY) ? UNITY : cfg.mix;
	assign fb_c   = (cfg.fb > FB_MAX) ? FB_MAX : cfg.fb;
	assign base_c = (cfg.base == '0) ? 17'd1 : cfg.base;
	assign pos_c  = pos_q[ch_q];

	assign tb_c = clamp_tap(35'(base_c) * 35'(cb_q));
	assign tc_c = clamp_tap(35'(base_c) * 35'(cc_q));
	assign ia_c = pos_c - DEPTH_W'(base_c);
	assign ib_c = pos_c - tb_c;
	assign ic_c = pos_c - tc_c;

	assign wet_sum_c = 44'(pa_q) + 44'(pb_q) + (44'(c_q) <<< 14) + 44'sd32768;
	assign lin_c     = 30'(x_q) + 30'((45'(pf_q) + 45'sd32768) >>> 16);
	assign axw_c     = mag(30'(wet_q));
	assign axl_c     = mag(lin_q);

	assign y_sum_c = 44'(m1_q) + 44'(m2_q) + 44'sd32768;
	assign y_c     = y_sum_c[42:16];
	assign y_sat_c = (y_c > 27'sd8388607) ? 24'sh7FFFFF :
	                 (y_c < -27'sd8388608) ? 24'sh800000 : y_c[SAMPLE_W-1:0];

	assign start    = (state_q == S_GO);
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign we       = (state_q == S_MIX);

	always_comb begin
		case (state_q)
			S_RDA:   raddr = {ch_q, ia_q};
			S_RDB:   raddr = {ch_q, ib_q};
			default: raddr = {ch_q, ic_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			store_q[{ch_q, pos_c}] <= sll_q;
		rd_q <= store_q[raddr];
	end

	mtfd_div u_div_wet (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (num_w_q),
		.den    (den_w_q),
		.done   (done_w),
		.quo    (qw)
	);

	mtfd_div u_div_line (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (num_l_q),
		.den    (den_l_q),
		.done   (done_l),
		.quo    (ql)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_q  <= head.item.ch;
				x_q   <= head.item.sample;
				byp_q <= head.item.bypass;
			end
			S_COEF: begin
				cb_q <= K_CB0 + 18'((34'(sp_c) * 34'(K_CB1) + 34'd32768) >> 16);
				cc_q <= K_CC0 + 18'((34'(sp_c) * 34'(K_CC1) + 34'd32768) >> 16);
				wb_q <= K_WB0 + 17'((34'(sp_c) * 34'(K_WB1) + 34'd32768) >> 16);
			end
			S_TAPS: begin
				ia_q <= ia_c;
				ib_q <= ib_c;
				ic_q <= ic_c;
				va_q <= wrap_q[ch_q] || (ia_c < pos_c);
				vb_q <= wrap_q[ch_q] || (ib_c < pos_c);
				vc_q <= wrap_q[ch_q] || (ic_c < pos_c);
			end
			S_RDB: a_q <= va_q ? rd_q : '0;
			S_RDC: b_q <= vb_q ? rd_q : '0;
			S_RDW: c_q <= vc_q ? rd_q : '0;
			S_MUL: begin
				pa_q <= a_q * $signed({1'b0, K_WA});
				pb_q <= b_q * $signed({1'b0, wb_q});
			end
			S_WET: wet_q <= wet_sum_c[43:16];
			S_FB:  pf_q  <= wet_q * $signed({1'b0, fb_c});
			S_LIN: lin_q <= lin_c;
			S_DEN: begin
				num_w_q <= soft_num(axw_c);
				den_w_q <= soft_den(axw_c);
				neg_w_q <= wet_q[27];
				num_l_q <= soft_num(axl_c);
				den_l_q <= soft_den(axl_c);
				neg_l_q <= lin_q[29];
			end
			S_DIV: begin
				if (done_w) begin
					slw_q <= neg_w_q ? -$signed({1'b0, qw}) : $signed({1'b0, qw});
					sll_q <= neg_l_q ? -$signed({1'b0, ql}) : $signed({1'b0, ql});
				end
			end
			S_MIX: begin
				m1_q <= x_q * $signed({1'b0, UNITY - mix_c});
				m2_q <= slw_q * $signed({1'b0, mix_c});
			end
			S_DONE: begin
				if (out_free)
					out_q <= byp_q ? x_q : y_sat_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (head.valid) state_q <= head.item.bypass ? S_DONE : S_COEF;
				S_COEF: state_q <= S_TAPS;
				S_TAPS: state_q <= S_RDA;
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_RDC;
				S_RDC:  state_q <= S_RDW;
				S_RDW:  state_q <= S_MUL;
				S_MUL:  state_q <= S_WET;
				S_WET:  state_q <= S_FB;
				S_FB:   state_q <= S_LIN;
				S_LIN:  state_q <= S_DEN;
				S_DEN:  state_q <= S_GO;
				S_GO:   state_q <= S_DIV;
				S_DIV:  if (done_w && done_l) state_q <= S_MIX;
				S_MIX: begin
					pos_q[ch_q] <= pos_c + 1'b1;
					if (pos_c == DEPTH_W'(DEPTH - 1))
						wrap_q[ch_q] <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

[hdl/mtfd_checker.sv]
`include "multi_tap_feedback_delay_assert.svh"

module mtfd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_out
);

	`MTFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`MTFD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(sample_out), "result changed while stalled")
	`MTFD_ASSERT_RST(a_rst_idle, !arst_n |-> !out_valid, "result shown during reset")
	`MTFD_ASSERT(a_full_after_req, $fell(in_ready) |-> $past(in_valid), "queue filled without a request")

endmodule

bind multi_tap_feedback_delay mtfd_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);
